/* hw/rtl/mutf8_pkg.sv */
// shared types, constants and helper functions for the modified utf-8 converter
// no dependencies; imported by mutf8_decoder, mutf8_res_fifo, the top level and the checker
package mutf8_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int MAX_RES       = 4;   // most results one input item can cause
    localparam int RES_DEPTH     = 8;   // result queue entries

    localparam logic [7:0]  LEAD_MIN2 = 8'hC2;
    localparam logic [7:0]  NUL_LEAD  = 8'hC0;
    localparam logic [7:0]  CONT_MIN  = 8'h80;
    localparam logic [15:0] SUR_HI    = 16'hD800;
    localparam logic [15:0] SUR_LO    = 16'hDC00;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_EOI     = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
        t_err       code;
    } t_res_ctrl;

    typedef struct packed {
        t_res_ctrl [MAX_RES-1:0] ent;
        logic [2:0]              n;
    } t_bundle;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] b;
        logic [2:0]              n;
    } t_enc;

    function automatic logic cont_byte(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic [15:0] triple(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
        return {a[3:0], b[5:0], c[5:0]};
    endfunction

    // standard utf-8 encoding of one code point, lead byte in b[0]
    function automatic t_enc encode(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp < SUPP_BASE) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

endpackage

/* hw/rtl/mutf8_decoder.sv */
// sequence state and single-pass decode of one input byte into a bundle of results
// depends on mutf8_pkg
module mutf8_decoder #(
    parameter int POS_WIDTH = mutf8_pkg::POS_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_acc,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output mutf8_pkg::t_bundle     o_bundle,
    output logic [POS_WIDTH-1:0]   o_err_pos
);
    import mutf8_pkg::*;

    logic [7:0]           r_seq_b [5];
    logic [2:0]           r_seq_count;
    logic [POS_WIDTH-1:0] r_seq_start;
    logic [POS_WIDTH-1:0] r_byte_offset;
    logic                 r_draining;

    t_err                 err;
    logic [POS_WIDTH-1:0] epos;
    logic                 emit;
    logic                 hold;
    logic [20:0]          cp;
    logic [15:0]          v3;
    logic [15:0]          hi;
    logic [15:0]          lo;
    t_enc                 enc;

    always_comb begin
        err  = ERR_NONE;
        epos = '0;
        emit = 1'b0;
        hold = 1'b0;
        cp   = '0;
        v3   = triple(r_seq_b[0], r_seq_b[1], i_byte);
        hi   = triple(r_seq_b[0], r_seq_b[1], r_seq_b[2]);
        lo   = triple(r_seq_b[3], r_seq_b[4], i_byte);
        if (!r_draining) begin
            if (r_seq_count == 3'd0) begin
                if (i_byte == 8'h00) begin
                    err  = ERR_INVALID;
                    epos = r_byte_offset;
                end else if (i_byte < CONT_MIN) begin
                    emit = 1'b1;
                    cp   = {13'd0, i_byte};
                end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110) begin
                    if (i_last) begin
                        err  = ERR_EOI;
                        epos = r_byte_offset;
                    end else begin
                        hold = 1'b1;
                    end
                end else begin
                    err  = ERR_INVALID;
                    epos = r_byte_offset;
                end
            end else if (r_seq_b[0][7:5] == 3'b110) begin
                if (!cont_byte(i_byte)) begin
                    err  = ERR_INVALID;
                    epos = r_byte_offset;
                end else if (r_seq_b[0] == NUL_LEAD && i_byte == CONT_MIN) begin
                    emit = 1'b1;
                end else if (r_seq_b[0] < LEAD_MIN2) begin
                    err  = ERR_INVALID;
                    epos = r_seq_start;
                end else begin
                    emit = 1'b1;
                    cp   = {10'd0, r_seq_b[0][4:0], i_byte[5:0]};
                end
            end else if (r_seq_count == 3'd1) begin
                if (i_last) begin
                    err  = ERR_EOI;
                    epos = r_seq_start;
                end else if (!cont_byte(i_byte)) begin
                    err  = ERR_INVALID;
                    epos = r_seq_start;
                end else begin
                    hold = 1'b1;
                end
            end else if (r_seq_count == 3'd2) begin
                if (!cont_byte(i_byte) || v3 < 16'h0800 || v3[15:10] == SUR_LO[15:10]) begin
                    err  = ERR_INVALID;
                    epos = r_seq_start;
                end else if (v3[15:10] == SUR_HI[15:10]) begin
                    // high surrogate, wait for its partner triple
                    if (i_last) begin
                        err  = ERR_INVALID;
                        epos = r_seq_start;
                    end else begin
                        hold = 1'b1;
                    end
                end else begin
                    emit = 1'b1;
                    cp   = {5'd0, v3};
                end
            end else if (r_seq_count < 3'd5) begin
                if (i_last) begin
                    err  = ERR_INVALID;
                    epos = r_seq_start;
                end else begin
                    hold = 1'b1;
                end
            end else begin
                if (r_seq_b[3][7:4] != 4'b1110 || !cont_byte(r_seq_b[4]) ||
                    !cont_byte(i_byte) || lo[15:10] != SUR_LO[15:10]) begin
                    err  = ERR_INVALID;
                    epos = r_seq_start + POS_WIDTH'(3);
                end else begin
                    emit = 1'b1;
                    cp   = SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
                end
            end
        end
    end

    always_comb begin
        enc      = encode(cp);
        o_bundle = '0;
        if (i_acc && err != ERR_NONE) begin
            o_bundle.n                 = 3'd1;
            o_bundle.ent[0].data       = 8'h00;
            o_bundle.ent[0].run_last   = 1'b1;
            o_bundle.ent[0].string_end = 1'b1;
            o_bundle.ent[0].code       = err;
        end else if (i_acc && emit) begin
            o_bundle.n = enc.n;
            for (int k = 0; k < MAX_RES; k++) begin
                o_bundle.ent[k].data       = enc.b[k];
                o_bundle.ent[k].run_last   = (3'(k) == enc.n - 3'd1);
                o_bundle.ent[k].string_end = (3'(k) == enc.n - 3'd1) && i_last;
                o_bundle.ent[k].code       = ERR_NONE;
            end
        end
    end

    assign o_err_pos = epos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count   <= '0;
            r_seq_start   <= '0;
            r_byte_offset <= '0;
            r_draining    <= 1'b0;
        end else if (i_acc) begin
            r_byte_offset <= r_byte_offset + POS_WIDTH'(1);
            if (!r_draining) begin
                if (r_seq_count == 3'd0) begin
                    r_seq_start <= r_byte_offset;
                end
                if (err != ERR_NONE) begin
                    r_seq_count <= '0;
                    r_draining  <= !i_last;
                end else if (emit) begin
                    r_seq_count <= '0;
                end else if (hold) begin
                    r_seq_count <= r_seq_count + 3'd1;
                end
            end
            if (i_last) begin
                r_byte_offset <= '0;
                r_seq_count   <= '0;
                r_draining    <= 1'b0;
            end
        end
    end

    // held sequence bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_acc && hold) begin
            r_seq_b[r_seq_count] <= i_byte;
        end
    end

endmodule

/* hw/rtl/mutf8_res_fifo.sv */
// result queue: takes a bundle of up to four results at once, hands out one per cycle while i_pop is high
// depends on mutf8_pkg
module mutf8_res_fifo #(
    parameter int POS_WIDTH = mutf8_pkg::POS_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mutf8_pkg::t_bundle     i_bundle,
    input  logic [POS_WIDTH-1:0]   i_err_pos,
    input  logic                   i_pop,
    output logic                   o_room,
    output logic                   o_valid,
    output mutf8_pkg::t_res_ctrl   o_ctrl,
    output logic [POS_WIDTH-1:0]   o_pos
);
    import mutf8_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_res_ctrl            r_ctrl [RES_DEPTH];
    logic [POS_WIDTH-1:0] r_pos  [RES_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_W'(RES_DEPTH - MAX_RES));
    assign o_ctrl  = r_ctrl[r_rd_ptr];
    assign o_pos   = r_pos[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (3'(k) < i_bundle.n) begin
                r_ctrl[r_wr_ptr + PTR_W'(k)] <= i_bundle.ent[k];
                r_pos[r_wr_ptr + PTR_W'(k)]  <= i_err_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_bundle.n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(i_bundle.n) - CNT_W'(pop);
        end
    end

endmodule

/* hw/rtl/mutf8_to_utf8_converter_unit.sv */
// top level of the modified utf-8 to standard utf-8 converter
// depends on mutf8_pkg, mutf8_decoder and mutf8_res_fifo
//
// Takes a string of java modified utf-8 one byte per item and gives standard
// utf-8 one byte per result item. A byte is decoded in the cycle it is taken,
// straight into an eight-entry result queue; its results show on the master
// side from the next cycle on, one per cycle while the master side takes them. The slave side takes one item
// per cycle whenever at most four results are queued, so a steady stream runs
// at one item per clock: a character never gives more bytes than it took,
// and only a burst of results that the master side does not take stalls the
// input. The limit on output is the single-read queue: one result per cycle.
// Errors give one result carrying the error code and the byte offset within
// the string; the rest of that string is then dropped up to its last byte.
module mutf8_to_utf8_converter_unit #(
    parameter  int POS_WIDTH = mutf8_pkg::POS_WIDTH_DEF,
    localparam int M_DW      = ((8 + POS_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // slave side
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,   // [7:0] in_byte
    input  logic            i_s_tlast,   // in_last
    // master side
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [M_DW-1:0] o_m_tdata,   // [7:0] out_byte, then error_pos, zero pad
    output logic [2:0]      o_m_tuser,   // [0] run_last, [2:1] error_code
    output logic            o_m_tlast    // string_end
);
    import mutf8_pkg::*;

    logic                 s_acc;      // item taken this cycle
    logic                 room;       // queue can absorb a full bundle
    t_bundle              bundle;
    logic [POS_WIDTH-1:0] err_pos;
    t_res_ctrl            head;
    logic [POS_WIDTH-1:0] head_pos;

    assign o_s_tready = room;
    assign s_acc      = i_s_tvalid && room;

    // decode of the byte against the open sequence
    mutf8_decoder #(
        .POS_WIDTH (POS_WIDTH)
    ) u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (s_acc),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_bundle  (bundle),
        .o_err_pos (err_pos)
    );

    // queued results, drained one per master handshake
    mutf8_res_fifo #(
        .POS_WIDTH (POS_WIDTH)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bundle  (bundle),
        .i_err_pos (err_pos),
        .i_pop     (i_m_tready),
        .o_room    (room),
        .o_valid   (o_m_tvalid),
        .o_ctrl    (head),
        .o_pos     (head_pos)
    );

    // output packing, pad bits stay zero
    assign o_m_tdata = M_DW'({head_pos, head.data});
    assign o_m_tuser = {head.code, head.run_last};
    assign o_m_tlast = head.string_end;

endmodule

/* test/mutf8_conv_checker.sv */
// result checker for mutf8_to_utf8_converter_unit: watches both stream channels,
// predicts the standard utf-8 items of every accepted input byte and compares them
// depends on mutf8_pkg for the error code type
module mutf8_conv_checker #(
    parameter int POS_WIDTH = 32,
    parameter int M_DW      = ((8 + POS_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [7:0]      i_s_tdata,   // [7:0] in_byte
    input  logic            i_s_tlast,   // in_last
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    input  logic [M_DW-1:0] i_m_tdata,   // [7:0] out_byte, then error_pos
    input  logic [2:0]      i_m_tuser,   // [0] run_last, [2:1] error_code
    input  logic            i_m_tlast,   // string_end
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mutf8_pkg::*;

    typedef struct {
        logic [7:0]           data;
        logic                 run_last;
        logic                 str_end;
        t_err                 code;
        logic [POS_WIDTH-1:0] pos;
    } t_utf8_item;

    t_utf8_item           pending_utf8 [$];
    int                   mismatches = 0;

    // decoder state
    logic [7:0]           held [5];
    int                   held_n;
    logic [POS_WIDTH-1:0] lead_pos;
    logic [POS_WIDTH-1:0] byte_pos;
    logic                 dropping;

    function automatic logic is_trail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic [15:0] tri_val(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        return {a[3:0], b[5:0], c[5:0]};
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (held_n < 5) begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void add_expected(input logic [7:0] d, input logic rl, input logic se,
                                         input t_err c, input logic [POS_WIDTH-1:0] p);
        t_utf8_item it;
        it.data      = d;
        it.run_last  = rl;
        it.str_end   = se;
        it.code      = c;
        it.pos       = p;
        pending_utf8 = {pending_utf8, it};
    endfunction

    // expected output items for one accepted modified utf-8 byte
    task automatic decode_mutf8_byte(input logic [7:0] b, input logic is_end);
        logic [POS_WIDTH-1:0] here;
        logic [POS_WIDTH-1:0] err_at;
        t_err                 err;
        logic                 emit;
        logic [20:0]          cp;
        logic [15:0]          v;
        logic [15:0]          lo;
        logic [7:0]           enc [4];
        int                   n;
        here     = byte_pos;
        byte_pos = byte_pos + POS_WIDTH'(1);
        err      = ERR_NONE;
        err_at   = '0;
        emit     = 1'b0;
        cp       = '0;
        n        = 0;
        if (!dropping) begin
            if (held_n == 0) begin
                lead_pos = here;
                if (b == 8'h00) begin
                    err    = ERR_INVALID;
                    err_at = here;
                end else if (b < 8'h80) begin
                    emit = 1'b1;
                    cp   = {13'd0, b};
                end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
                    if (is_end) begin
                        err    = ERR_EOI;
                        err_at = here;
                    end else begin
                        hold_byte(b);
                    end
                end else begin
                    err    = ERR_INVALID;
                    err_at = here;
                end
            end else if (held[0][7:5] == 3'b110) begin
                if (!is_trail(b)) begin
                    err    = ERR_INVALID;
                    err_at = here;
                end else if (held[0] == 8'hC0 && b == 8'h80) begin
                    emit = 1'b1;
                    cp   = '0;
                end else if (held[0] < 8'hC2) begin
                    err    = ERR_INVALID;
                    err_at = lead_pos;
                end else begin
                    emit = 1'b1;
                    cp   = {10'd0, held[0][4:0], b[5:0]};
                end
            end else if (held_n == 1) begin
                if (is_end) begin
                    err    = ERR_EOI;
                    err_at = lead_pos;
                end else if (!is_trail(b)) begin
                    err    = ERR_INVALID;
                    err_at = lead_pos;
                end else begin
                    hold_byte(b);
                end
            end else if (held_n == 2) begin
                v = tri_val(held[0], held[1], b);
                if (!is_trail(b) || v < 16'h0800 || (v >= 16'hDC00 && v <= 16'hDFFF)) begin
                    err    = ERR_INVALID;
                    err_at = lead_pos;
                end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
                    if (is_end) begin
                        err    = ERR_INVALID;
                        err_at = lead_pos;
                    end else begin
                        hold_byte(b);
                    end
                end else begin
                    emit = 1'b1;
                    cp   = {5'd0, v};
                end
            end else if (held_n < 5) begin
                if (is_end) begin
                    err    = ERR_INVALID;
                    err_at = lead_pos;
                end else begin
                    hold_byte(b);
                end
            end else begin
                // high surrogate is held, so its low ten bits are the upper half
                v  = tri_val(held[0], held[1], held[2]);
                lo = tri_val(held[3], held[4], b);
                if (held[3][7:4] != 4'b1110 || !is_trail(held[4]) || !is_trail(b) ||
                    lo < 16'hDC00 || lo > 16'hDFFF) begin
                    err    = ERR_INVALID;
                    err_at = lead_pos + POS_WIDTH'(3);
                end else begin
                    emit = 1'b1;
                    cp   = 21'h10000 + {1'b0, v[9:0], lo[9:0]};
                end
            end

            if (err != ERR_NONE) begin
                add_expected(8'h00, 1'b1, 1'b1, err, err_at);
                held_n   = 0;
                dropping = !is_end;
            end else if (emit) begin
                if (cp < 21'h80) begin
                    enc[0] = cp[7:0];
                    n      = 1;
                end else if (cp < 21'h800) begin
                    enc[0] = {3'b110, cp[10:6]};
                    enc[1] = {2'b10, cp[5:0]};
                    n      = 2;
                end else if (cp < 21'h10000) begin
                    enc[0] = {4'b1110, cp[15:12]};
                    enc[1] = {2'b10, cp[11:6]};
                    enc[2] = {2'b10, cp[5:0]};
                    n      = 3;
                end else begin
                    enc[0] = {5'b11110, cp[20:18]};
                    enc[1] = {2'b10, cp[17:12]};
                    enc[2] = {2'b10, cp[11:6]};
                    enc[3] = {2'b10, cp[5:0]};
                    n      = 4;
                end
                for (int k = 0; k < n; k++) begin
                    add_expected(enc[k], k == n - 1, (k == n - 1) && is_end, ERR_NONE, '0);
                end
                held_n = 0;
            end
        end
        if (is_end) begin
            byte_pos = '0;
            held_n   = 0;
            dropping = 1'b0;
        end
    endtask

    task automatic check_utf8_out();
        t_utf8_item want;
        if (pending_utf8.size() == 0) begin
            $display("%0t: unexpected item byte %h run_last %b end %b code %0d pos %0d",
                     $time, i_m_tdata[7:0], i_m_tuser[0], i_m_tlast, i_m_tuser[2:1],
                     i_m_tdata[8 +: POS_WIDTH]);
            mismatches++;
        end else begin
            want = pending_utf8.pop_front();
            if (i_m_tdata[7:0] !== want.data || i_m_tuser[0] !== want.run_last ||
                i_m_tlast !== want.str_end || i_m_tuser[2:1] !== want.code ||
                i_m_tdata[8 +: POS_WIDTH] !== want.pos) begin
                $display("%0t: expected byte %h run_last %b end %b code %0d pos %0d",
                         $time, want.data, want.run_last, want.str_end, want.code,
                         want.pos);
                $display("%0t:   actual byte %h run_last %b end %b code %0d pos %0d",
                         $time, i_m_tdata[7:0], i_m_tuser[0], i_m_tlast,
                         i_m_tuser[2:1], i_m_tdata[8 +: POS_WIDTH]);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_n   = 0;
            lead_pos = '0;
            byte_pos = '0;
            dropping = 1'b0;
            pending_utf8.delete();
        end else begin
            // a result is never seen in the same cycle as its byte is taken
            if (i_s_tvalid && i_s_tready) begin
                decode_mutf8_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_utf8_out();
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_utf8.size();
    end

endmodule

/* test/tb.sv */
// testbench top for mutf8_to_utf8_converter_unit: clock, reset, byte stimulus,
// output back-pressure, stall watchdog and the final verdict
// depends on mutf8_pkg, the converter rtl and mutf8_conv_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_WIDTH    = 32;
    localparam int M_DW         = ((8 + POS_WIDTH + 7) / 8) * 8;
    localparam int RESET_CYCLES = 7;
    localparam int STIM_ITEMS   = 200;   // directed strings, then random ones up to this
    localparam int PHASE_ITEMS  = 77;    // items per idling phase
    localparam int HOLD_OFF     = 50;    // cycles the receiver blocks in the pressure phase
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 16;

    logic            i_clk;
    logic            i_rst_n    = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [7:0]      i_s_tdata  = 8'h00;   // [7:0] in_byte
    logic            i_s_tlast  = 1'b0;    // in_last
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [M_DW-1:0] o_m_tdata;            // [7:0] out_byte, then error_pos
    logic [2:0]      o_m_tuser;            // [0] run_last, [2:1] error_code
    logic            o_m_tlast;            // string_end

    int              fail_count;
    int              pending_results;

    // idling rates in percent, stepped by the stimulus as items go out
    int unsigned     sender_idle_pct = 20;
    int unsigned     recv_idle_pct   = 48;
    logic            hold_off_due    = 1'b0;
    int              items_sent      = 0;

    // bytes of the string being built, sent with tlast on the final one
    logic [7:0]      text_q [$];

    mutf8_to_utf8_converter_unit #(
        .POS_WIDTH(POS_WIDTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    mutf8_conv_checker #(
        .POS_WIDTH(POS_WIDTH),
        .M_DW     (M_DW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // offer one byte, with random gaps before it, and wait until it is taken
    task automatic send_item(input logic [7:0] b, input logic is_end);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= is_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        // swap the idling sides, then run flat out with one long output stall
        if (items_sent == PHASE_ITEMS) begin
            sender_idle_pct = 48;
            recv_idle_pct   = 20;
        end else if (items_sent == 2 * PHASE_ITEMS) begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
            hold_off_due    = 1'b1;
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_item(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // one more byte on the end of the string being built
    function automatic void add_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    // code unit as a modified utf-8 triple
    function automatic void push_triple(input logic [15:0] v);
        add_byte({4'b1110, v[15:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
    endfunction

    // stimulus and verdict
    initial begin
        int          n_chars;
        int unsigned kind;
        int          first;
        logic [15:0] unit16;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top ascii, encoded nul, largest bmp value and a surrogate pair in one string
        text_q = '{8'h7F, 8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80};
        send_text();
        // bare zero, then the rest of the string is dropped
        text_q = '{8'h00, 8'h41};
        send_text();
        // leads that can never start a character
        text_q = '{8'h80};
        send_text();
        text_q = '{8'hFF};
        send_text();
        // overlong two-byte form
        text_q = '{8'hC1, 8'hBF};
        send_text();
        // two-byte form whose second byte is no continuation
        text_q = '{8'hC2, 8'h41};
        send_text();
        // string cut short inside a three-byte form
        text_q = '{8'hE2, 8'h82};
        send_text();
        // lone low surrogate
        text_q = '{8'hED, 8'hB0, 8'h80};
        send_text();
        // high surrogate with nothing after it
        text_q = '{8'hED, 8'hA0, 8'h80};
        send_text();

        // random strings: mostly well-formed characters, some spoilt ones and noise
        while (items_sent < STIM_ITEMS) begin
            n_chars = $urandom_range(1, 6);
            repeat (n_chars) begin
                kind = $urandom_range(99);
                if (kind < 35) begin
                    add_byte(8'($urandom_range(1, 127)));
                end else if (kind < 40) begin
                    add_byte(8'hC0);
                    add_byte(8'h80);
                end else if (kind < 55) begin
                    add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                    add_byte(8'($urandom_range(8'h80, 8'hBF)));
                end else if (kind < 67) begin
                    // now and then an overlong value
                    if ($urandom_range(7) == 0) begin
                        unit16 = 16'($urandom_range(0, 16'h07FF));
                    end else begin
                        unit16 = 16'($urandom_range(16'h0800, 16'hFFFF));
                    end
                    push_triple(unit16);
                end else if (kind < 92) begin
                    first = text_q.size();
                    push_triple(16'($urandom_range(16'hD800, 16'hDBFF)));
                    push_triple(16'($urandom_range(16'hDC00, 16'hDFFF)));
                    // spoil one byte of the pair now and then
                    if (kind >= 80) begin
                        text_q[first + $urandom_range(5)] = 8'($urandom_range(255));
                    end
                end else begin
                    add_byte(8'($urandom_range(255)));
                end
            end
            // some strings lose one or two bytes off their end, which can cut their final character short
            if ($urandom_range(4) == 0 && text_q.size() > 2) begin
                repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
            end
            send_text();
        end
        i_s_tvalid <= 1'b0;

        // let the checker see the last byte before waiting for the output to drain
        @(posedge i_clk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("mutf8_to_utf8_converter_unit: match");
        end else begin
            $display("mutf8_to_utf8_converter_unit: mismatch");
        end
        $finish;
    end

    // output back-pressure, with one long hold-off once the sender runs flat out
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_due && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // give up when neither side has moved an item for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("mutf8_to_utf8_converter_unit: mismatch");
        $finish;
    end

endmodule
